// ===== rtl/stable_priority_queue_top_assert.svh =====
// Assertion macros shared by the checker of the stable priority queue.
// Each macro places one labeled concurrent assertion clocked on clk and
// disabled while arst_n is low.
`ifndef STABLE_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define STABLE_PRIORITY_QUEUE_TOP_ASSERT_SVH

// Same-cycle implication.
`define SPQ_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("queue check failed");

// Next-cycle implication.
`define SPQ_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("queue check failed");

`endif

// ===== rtl/spq_pkg.sv =====
`timescale 1ns / 1ps
package spq_pkg;

	// Capacity of the queue, in entries.
	localparam int QUEUE_DEPTH = 16;

	// Field widths.
	localparam int PRIO_W = 2;
	localparam int TAG_W  = 8;
	localparam int STAT_W = 2;
	localparam int OCC_W  = 5;

	// One FIFO lane per priority level.
	localparam int PRIO_N = 1 << PRIO_W;

	// Pointer into one lane, total count, and the storage address.
	localparam int PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
	localparam int ADDR_W    = PRIO_W + PTR_W;
	localparam int MEM_DEPTH = PRIO_N << PTR_W;

	// Operation codes.
	localparam logic OP_ENQ = 1'b0;
	localparam logic OP_DEQ = 1'b1;

	// Result status codes.
	localparam logic [STAT_W-1:0] STAT_ENQ   = 2'd0;
	localparam logic [STAT_W-1:0] STAT_DEQ   = 2'd1;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd3;

	// Result word handed from the controller to the output register.
	typedef struct packed {
		logic              load;
		logic [STAT_W-1:0] status;
		logic [TAG_W-1:0]  tag;
		logic [PRIO_W-1:0] prio;
		logic [OCC_W-1:0]  occ;
	} res_t;

	// Occupancy carries the low bits of the count.
	function automatic logic [OCC_W-1:0] occ_of(input logic [CNT_W-1:0] cnt);
		return OCC_W'(cnt);
	endfunction

	// Lane pointer advance with wrap at the lane depth.
	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + 1'b1;
		end
		return r;
	endfunction

endpackage

// ===== rtl/spq_mem.sv =====
`timescale 1ns / 1ps
module spq_mem (
	input  logic                      clk,
	input  logic                      we,
	input  logic [spq_pkg::ADDR_W-1:0] waddr,
	input  logic [spq_pkg::TAG_W-1:0]  wdata,
	input  logic                      re,
	input  logic [spq_pkg::ADDR_W-1:0] raddr,
	output logic [spq_pkg::TAG_W-1:0]  rdata
);

	logic [spq_pkg::TAG_W-1:0] mem_q [spq_pkg::MEM_DEPTH];
	logic [spq_pkg::TAG_W-1:0] rdata_q;

	// Tag storage, one region per priority lane.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/spq_ctrl.sv =====
`timescale 1ns / 1ps
module spq_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       opcode,
	input  logic [spq_pkg::PRIO_W-1:0] priority_req,
	input  logic [spq_pkg::TAG_W-1:0]  item_tag,
	input  logic                       out_free,
	output logic                       mem_we,
	output logic [spq_pkg::ADDR_W-1:0] mem_waddr,
	output logic [spq_pkg::TAG_W-1:0]  mem_wdata,
	output logic                       mem_re,
	output logic [spq_pkg::ADDR_W-1:0] mem_raddr,
	input  logic [spq_pkg::TAG_W-1:0]  mem_rdata,
	output spq_pkg::res_t              res
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_READ = 1'b1;

	logic                       state_q;
	logic [spq_pkg::CNT_W-1:0]  total_q;
	logic [spq_pkg::PTR_W-1:0]  head_q [spq_pkg::PRIO_N];
	logic [spq_pkg::PTR_W-1:0]  tail_q [spq_pkg::PRIO_N];
	logic [spq_pkg::CNT_W-1:0]  lane_cnt_q [spq_pkg::PRIO_N];
	logic [spq_pkg::PRIO_W-1:0] prio_s1;

	logic                       accept;
	logic                       full;
	logic                       empty;
	logic                       do_enq;
	logic                       do_deq;
	logic [spq_pkg::PRIO_W-1:0] top_prio;

	// Handshake and the outcome of the accepted word.
	assign in_ready = (state_q == S_IDLE) && out_free;
	assign accept   = in_valid && in_ready;
	assign full     = (total_q == spq_pkg::CNT_W'(spq_pkg::QUEUE_DEPTH));
	assign empty    = (total_q == '0);
	assign do_enq   = accept && (opcode == spq_pkg::OP_ENQ) && !full;
	assign do_deq   = accept && (opcode == spq_pkg::OP_DEQ) && !empty;

	// Highest lane that holds an entry.
	always_comb begin
		top_prio = '0;
		for (int i = 0; i < spq_pkg::PRIO_N; i++) begin
			if (lane_cnt_q[i] != '0) begin
				top_prio = spq_pkg::PRIO_W'(i);
			end
		end
	end

	// An enqueue writes at the tail of its lane; a dequeue reads the head of
	// the top lane. Both never happen in one cycle, and the read data is
	// consumed in the very next cycle, so no forwarding is needed.
	assign mem_we    = do_enq;
	assign mem_waddr = {priority_req, tail_q[priority_req]};
	assign mem_wdata = item_tag;
	assign mem_re    = do_deq;
	assign mem_raddr = {top_prio, head_q[top_prio]};

	// Result word: immediate for enqueue and empty dequeue, in the next cycle
	// for a dequeue that waits on the memory.
	always_comb begin
		res.load   = (accept && !do_deq) || (state_q == S_READ);
		res.tag    = '0;
		res.prio   = '0;
		res.occ    = spq_pkg::occ_of(total_q);
		res.status = spq_pkg::STAT_EMPTY;
		if (state_q == S_READ) begin
			res.status = spq_pkg::STAT_DEQ;
			res.tag    = mem_rdata;
			res.prio   = prio_s1;
		end else if (opcode == spq_pkg::OP_ENQ) begin
			if (full) begin
				res.status = spq_pkg::STAT_FULL;
			end else begin
				res.status = spq_pkg::STAT_ENQ;
				res.occ    = spq_pkg::occ_of(total_q + 1'b1);
			end
		end
	end

	// Sequencer and total count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			total_q <= '0;
		end else begin
			state_q <= do_deq ? S_READ : S_IDLE;
			if (do_enq) begin
				total_q <= total_q + 1'b1;
			end else if (do_deq) begin
				total_q <= total_q - 1'b1;
			end
		end
	end

	// Lane of the pending dequeue.
	always_ff @(posedge clk) begin
		if (do_deq) begin
			prio_s1 <= top_prio;
		end
	end

	// Per-lane FIFO pointers and counts.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < spq_pkg::PRIO_N; i++) begin
				head_q[i]     <= '0;
				tail_q[i]     <= '0;
				lane_cnt_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < spq_pkg::PRIO_N; i++) begin
				if (do_enq && (priority_req == spq_pkg::PRIO_W'(i))) begin
					tail_q[i]     <= spq_pkg::ptr_inc(tail_q[i]);
					lane_cnt_q[i] <= lane_cnt_q[i] + 1'b1;
				end else if (do_deq && (top_prio == spq_pkg::PRIO_W'(i))) begin
					head_q[i]     <= spq_pkg::ptr_inc(head_q[i]);
					lane_cnt_q[i] <= lane_cnt_q[i] - 1'b1;
				end
			end
		end
	end

endmodule

// ===== rtl/stable_priority_queue_top.sv =====
`timescale 1ns / 1ps
// Stable priority queue: entries leave highest priority first, and first in,
// first out among entries of equal priority.
// Input channel (in_valid/in_ready): opcode, priority_req, item_tag. Opcode
// enqueue stores the tag, opcode dequeue removes the head entry.
// Output channel (out_valid/out_ready): one word per input word with status,
// out_tag, out_priority and the occupancy after the operation.
// Entries sit in one tag memory split into one FIFO lane per priority level;
// a dequeue reads the head of the highest non-empty lane.
// An enqueue or a refused operation shows its result in the cycle after
// acceptance; a successful dequeue passes through the registered memory
// read and then the output register. One enqueue is taken per cycle while
// the output register is free, and no word is taken during a dequeue read.
// Reset empties the queue at once: all lane pointers and counts clear, and no
// memory sweep is needed. A stalled receiver holds the result word in the
// output register; a new input word is taken only when that register is
// free or being read in the same cycle.
module stable_priority_queue_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       opcode,
	input  logic [spq_pkg::PRIO_W-1:0] priority_req,
	input  logic [spq_pkg::TAG_W-1:0]  item_tag,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [spq_pkg::STAT_W-1:0] status,
	output logic [spq_pkg::TAG_W-1:0]  out_tag,
	output logic [spq_pkg::PRIO_W-1:0] out_priority,
	output logic [spq_pkg::OCC_W-1:0]  occupancy
);

	logic                       out_valid_q;
	logic [spq_pkg::STAT_W-1:0] status_q;
	logic [spq_pkg::TAG_W-1:0]  tag_q;
	logic [spq_pkg::PRIO_W-1:0] prio_q;
	logic [spq_pkg::OCC_W-1:0]  occ_q;
	logic                       out_free;
	logic                       mem_we;
	logic [spq_pkg::ADDR_W-1:0] mem_waddr;
	logic [spq_pkg::TAG_W-1:0]  mem_wdata;
	logic                       mem_re;
	logic [spq_pkg::ADDR_W-1:0] mem_raddr;
	logic [spq_pkg::TAG_W-1:0]  mem_rdata;
	spq_pkg::res_t              res;

	assign out_free = !out_valid_q || out_ready;

	spq_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.opcode       (opcode),
		.priority_req (priority_req),
		.item_tag     (item_tag),
		.out_free     (out_free),
		.mem_we       (mem_we),
		.mem_waddr    (mem_waddr),
		.mem_wdata    (mem_wdata),
		.mem_re       (mem_re),
		.mem_raddr    (mem_raddr),
		.mem_rdata    (mem_rdata),
		.res          (res)
	);

	spq_mem u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Output word valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output word payload.
	always_ff @(posedge clk) begin
		if (res.load) begin
			status_q <= res.status;
			tag_q    <= res.tag;
			prio_q   <= res.prio;
			occ_q    <= res.occ;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign out_tag      = tag_q;
	assign out_priority = prio_q;
	assign occupancy    = occ_q;

endmodule

// ===== rtl/spq_checker.sv =====
`timescale 1ns / 1ps
`include "stable_priority_queue_top_assert.svh"
module spq_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       opcode,
	input logic [spq_pkg::PRIO_W-1:0] priority_req,
	input logic [spq_pkg::TAG_W-1:0]  item_tag,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [spq_pkg::STAT_W-1:0] status,
	input logic [spq_pkg::TAG_W-1:0]  out_tag,
	input logic [spq_pkg::PRIO_W-1:0] out_priority,
	input logic [spq_pkg::OCC_W-1:0]  occupancy
);

	logic in_seen;

	assign in_seen = in_valid && in_ready && (opcode == spq_pkg::OP_ENQ)
		&& (priority_req != '0 || item_tag != '0 || priority_req == '0);

	// Only a dequeued word carries a tag and a priority.
	`SPQ_ASSERT_NOW(a_idle_fields, out_valid && (status != spq_pkg::STAT_DEQ),
		(out_tag == '0) && (out_priority == '0))

	// An empty report means the queue holds nothing.
	`SPQ_ASSERT_NOW(a_empty_occ, out_valid && (status == spq_pkg::STAT_EMPTY),
		occupancy == '0)

	// A refused enqueue means the queue is at capacity.
	`SPQ_ASSERT_NOW(a_full_occ, out_valid && (status == spq_pkg::STAT_FULL),
		occupancy == spq_pkg::OCC_W'(spq_pkg::QUEUE_DEPTH))

	// An accepted enqueue yields its result in the next cycle.
	`SPQ_ASSERT_NEXT(a_enq_result, in_seen,
		out_valid && ((status == spq_pkg::STAT_ENQ) || (status == spq_pkg::STAT_FULL)))

	// A stalled output word holds its status, tag and occupancy.
	`SPQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(status) && $stable(out_tag) && $stable(occupancy))

endmodule

bind stable_priority_queue_top spq_checker u_spq_checker (.*);
